// ===== sv/ptt_pkg.sv =====
// Shared constants, register indexes and control types for the pulse tachometer.
`default_nettype none

package ptt_pkg;

    localparam int TIME_BITS_DEF = 32;

    localparam int TIMEOUT_W  = 16;
    localparam int LIMIT_W    = 20;
    localparam int RPM_W      = 16;
    localparam int TONE_W     = 30;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    // shared restoring divider
    localparam int DIV_W      = 30;
    localparam int RPM_STEPS  = 16;
    localparam int TONE_STEPS = 30;
    localparam int CNT_W      = $clog2(TONE_STEPS);

    // periods below 2^15 are the only ones that can give a nonzero tone
    localparam int SQ_IN_W = 15;

    localparam logic [RPM_W-1:0]  RPM_NUM  = 16'd60000;
    localparam logic [TONE_W-1:0] TONE_NUM = 30'd720000000;

    // above these periods the quotient is zero
    localparam int RPM_MAX_PERIOD  = 60000;
    localparam int TONE_MAX_PERIOD = 26832;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST  = 16'd2500;
    localparam logic [LIMIT_W-1:0]   TONE_MIN_RST = 20'd10;
    localparam logic [LIMIT_W-1:0]   TONE_MAX_RST = 20'd20000;

    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TONE_MIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TONE_MAX = 2'd2;

    typedef struct packed {
        logic accept;
        logic update;
        logic check;
        logic div_load;
        logic div_tone;
        logic div_step;
        logic store_rpm;
        logic store_tone;
        logic emit;
    } ptt_cmd_t;

    typedef struct packed {
        logic out_room;
    } ptt_stat_t;

endpackage

`default_nettype wire

// ===== sv/pulse_tachometer_tone.sv =====
// Period-measuring tachometer with tone output: one item per millisecond tick.
// Input channel: in_valid with press, one item per tick; the block drives in_stall.
// Output channel: out_valid with running, rpm, led_on, tone_valid and tone_freq;
// the receiver drives out_stall. Every item gives exactly one result.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; index 0 is
// timeout_ms, 1 is tone_min, 2 is tone_max. cfg_ready is always high; write
// only while no item is in flight.
// The shared restoring divider works out rpm and then the tone, one quotient
// bit per cycle. The block takes no new item while one is in flight: in_stall
// stays high until the result has been written to the result register.
// The result register frees the divider: a stalled result holds its value,
// and the next item waits in the last step until the register can take it.
// Reset clears the millisecond clock, last press time and period, sets the
// blink indicator and loads the default timeout and tone limits.
`default_nettype none

module pulse_tachometer_tone #(
    parameter int TIME_BITS = ptt_pkg::TIME_BITS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic                           press,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic                                running,
    output logic [ptt_pkg::RPM_W-1:0]           rpm,
    output logic                                led_on,
    output logic                                tone_valid,
    output logic [ptt_pkg::TONE_W-1:0]          tone_freq,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [ptt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [ptt_pkg::CFG_DATA_W-1:0] cfg_data
);

    ptt_pkg::ptt_cmd_t  cmd;
    ptt_pkg::ptt_stat_t stat;

    assign cfg_ready = 1'b1;

    ptt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    ptt_datapath #(.TIME_BITS(TIME_BITS)) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .press      (press),
        .cfg_valid  (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .running    (running),
        .rpm        (rpm),
        .led_on     (led_on),
        .tone_valid (tone_valid),
        .tone_freq  (tone_freq)
    );

endmodule

`default_nettype wire

// ===== sv/ptt_div.sv =====
// Restoring divider, one quotient bit per cycle while step is high.
`default_nettype none

module ptt_div #(
    parameter int W = ptt_pkg::DIV_W
) (
    input  wire logic         clk,
    input  wire logic         load,
    input  wire logic         step,
    input  wire logic [W-1:0] dividend,
    input  wire logic [W-1:0] divisor,
    output logic      [W-1:0] quotient
);

    logic [W-1:0] rem_reg, rem_next;
    logic [W-1:0] dq_reg, dq_next;
    logic [W-1:0] dvs_reg;
    logic [W:0]   shifted;
    logic [W:0]   trial;
    logic         ge;

    always_comb
    begin
        shifted  = {rem_reg, dq_reg[W-1]};
        trial    = shifted - {1'b0, dvs_reg};
        ge       = (shifted >= {1'b0, dvs_reg});
        rem_next = ge ? trial[W-1:0] : shifted[W-1:0];
        dq_next  = {dq_reg[W-2:0], ge};
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rem_reg <= '0;
            dq_reg  <= dividend;
            dvs_reg <= divisor;
        end
        else if (step)
        begin
            rem_reg <= rem_next;
            dq_reg  <= dq_next;
        end
    end

    assign quotient = dq_reg;

endmodule

`default_nettype wire

// ===== sv/ptt_datapath.sv =====
// Tachometer datapath: time keeping, period, blink, divider and result register.
`default_nettype none

module ptt_datapath #(
    parameter int TIME_BITS = ptt_pkg::TIME_BITS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire ptt_pkg::ptt_cmd_t                cmd,
    output ptt_pkg::ptt_stat_t                    stat,
    input  wire logic                             press,
    input  wire logic                             cfg_valid,
    input  wire logic [ptt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [ptt_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                             out_stall,
    output logic                                  out_valid,
    output logic                                  running,
    output logic [ptt_pkg::RPM_W-1:0]             rpm,
    output logic                                  led_on,
    output logic                                  tone_valid,
    output logic [ptt_pkg::TONE_W-1:0]            tone_freq
);

    localparam int DW = ptt_pkg::DIV_W;
    localparam int RW = ptt_pkg::RPM_W;
    localparam int TW = ptt_pkg::TONE_W;

    logic [TIME_BITS-1:0] now_reg, last_reg, period_reg;
    logic                 blink_reg;
    logic [ptt_pkg::TIMEOUT_W-1:0] timeout_reg;
    logic [ptt_pkg::LIMIT_W-1:0]   tmin_reg, tmax_reg;
    logic                 out_valid_reg;

    logic                 press_reg;
    logic [TIME_BITS-1:0] elapsed_reg;
    logic                 run_reg, pzero_reg, rpm_big_reg, tone_big_reg;
    logic [TW-1:0]        sq_reg;
    logic [RW-1:0]        rpm_reg;
    logic [TW-1:0]        tone_reg;

    logic                 out_running_reg, out_led_reg, out_tvalid_reg;
    logic [RW-1:0]        out_rpm_reg;
    logic [TW-1:0]        out_tone_reg;

    logic [TIME_BITS-1:0] diff;
    logic                 timed_out;
    logic                 past_half;
    logic [DW-1:0]        div_dividend, div_divisor, quotient;
    logic                 tone_ok;

    assign diff      = now_reg - last_reg;
    assign timed_out = elapsed_reg > TIME_BITS'(timeout_reg);
    assign past_half = elapsed_reg > (period_reg >> 1);
    assign tone_ok   = run_reg && (tone_reg > TW'(tmin_reg)) && (tone_reg < TW'(tmax_reg));

    assign div_dividend = cmd.div_tone ? DW'(ptt_pkg::TONE_NUM)
                                       : (DW'(ptt_pkg::RPM_NUM) << (DW - RW));
    assign div_divisor  = cmd.div_tone ? sq_reg : DW'(period_reg[RW-1:0]);

    ptt_div #(.W(DW)) u_div (
        .clk      (clk),
        .load     (cmd.div_load),
        .step     (cmd.div_step),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (quotient)
    );

    // architectural state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_reg       <= '0;
            last_reg      <= '0;
            period_reg    <= '0;
            blink_reg     <= 1'b1;
            timeout_reg   <= ptt_pkg::TIMEOUT_RST;
            tmin_reg      <= ptt_pkg::TONE_MIN_RST;
            tmax_reg      <= ptt_pkg::TONE_MAX_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    ptt_pkg::CFG_TIMEOUT:  timeout_reg <= cfg_data[ptt_pkg::TIMEOUT_W-1:0];
                    ptt_pkg::CFG_TONE_MIN: tmin_reg    <= cfg_data;
                    ptt_pkg::CFG_TONE_MAX: tmax_reg    <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.accept)
                now_reg <= now_reg + 1'b1;
            if (cmd.update && press_reg)
            begin
                period_reg <= diff;
                last_reg   <= now_reg;
                blink_reg  <= 1'b1;
            end
            if (cmd.check && (last_reg != '0))
            begin
                if (timed_out)
                begin
                    period_reg <= '0;
                    last_reg   <= '0;
                end
                else if (past_half)
                    blink_reg <= 1'b0;
            end
            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // working values of the item in flight
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
            press_reg <= press;
        if (cmd.update)
            elapsed_reg <= press_reg ? '0 : diff;
        if (cmd.check)
        begin
            run_reg      <= (last_reg != '0) && !timed_out;
            pzero_reg    <= (period_reg == '0);
            rpm_big_reg  <= period_reg > TIME_BITS'(ptt_pkg::RPM_MAX_PERIOD);
            tone_big_reg <= period_reg > TIME_BITS'(ptt_pkg::TONE_MAX_PERIOD);
            sq_reg       <= TW'(period_reg[ptt_pkg::SQ_IN_W-1:0])
                          * TW'(period_reg[ptt_pkg::SQ_IN_W-1:0]);
        end
        if (cmd.store_rpm)
        begin
            if (!run_reg || (!pzero_reg && rpm_big_reg))
                rpm_reg <= '0;
            else if (pzero_reg)
                rpm_reg <= ptt_pkg::RPM_NUM;
            else
                rpm_reg <= quotient[RW-1:0];
        end
        if (cmd.store_tone)
        begin
            if (!run_reg || (!pzero_reg && tone_big_reg))
                tone_reg <= '0;
            else if (pzero_reg)
                tone_reg <= ptt_pkg::TONE_NUM;
            else
                tone_reg <= quotient[TW-1:0];
        end
        if (cmd.emit)
        begin
            out_running_reg <= run_reg;
            out_rpm_reg     <= rpm_reg;
            out_led_reg     <= blink_reg;
            out_tvalid_reg  <= tone_ok;
            out_tone_reg    <= tone_reg;
        end
    end

    assign stat.out_room = !out_valid_reg || !out_stall;

    assign out_valid  = out_valid_reg;
    assign running    = out_running_reg;
    assign rpm        = out_rpm_reg;
    assign led_on     = out_led_reg;
    assign tone_valid = out_tvalid_reg;
    assign tone_freq  = out_tone_reg;

    a_stopped_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_running_reg) |->
            (out_rpm_reg == '0) && (out_tone_reg == '0) && !out_tvalid_reg)
        else $error("stopped result carries nonzero rpm or tone");

endmodule

`default_nettype wire

// ===== sv/ptt_ctrl.sv =====
// Tachometer controller: sequences update, check, both divisions and the result.
`default_nettype none

module ptt_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire ptt_pkg::ptt_stat_t stat,
    output ptt_pkg::ptt_cmd_t       cmd
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_UPD  = 4'd1;
    localparam logic [3:0] S_CHK  = 4'd2;
    localparam logic [3:0] S_RLD  = 4'd3;
    localparam logic [3:0] S_RRUN = 4'd4;
    localparam logic [3:0] S_TLD  = 4'd5;
    localparam logic [3:0] S_TRUN = 4'd6;
    localparam logic [3:0] S_FIN  = 4'd7;
    localparam logic [3:0] S_EMIT = 4'd8;

    localparam int CW = ptt_pkg::CNT_W;

    logic [3:0]    state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_UPD;
                end
            end
            S_UPD:
            begin
                cmd.update = 1'b1;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                cmd.check  = 1'b1;
                state_next = S_RLD;
            end
            S_RLD:
            begin
                cmd.div_load = 1'b1;
                cnt_next     = CW'(ptt_pkg::RPM_STEPS - 1);
                state_next   = S_RRUN;
            end
            S_RRUN:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == '0)
                    state_next = S_TLD;
                else
                    cnt_next = cnt_reg - 1'b1;
            end
            S_TLD:
            begin
                // take the rpm quotient and start the tone division together
                cmd.store_rpm = 1'b1;
                cmd.div_load  = 1'b1;
                cmd.div_tone  = 1'b1;
                cnt_next      = CW'(ptt_pkg::TONE_STEPS - 1);
                state_next    = S_TRUN;
            end
            S_TRUN:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == '0)
                    state_next = S_FIN;
                else
                    cnt_next = cnt_reg - 1'b1;
            end
            S_FIN:
            begin
                cmd.store_tone = 1'b1;
                state_next     = S_EMIT;
            end
            S_EMIT:
            begin
                // hold until the result register is free
                if (stat.out_room)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == S_UPD))
        else $error("accepted item did not start the update");

    a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> stat.out_room)
        else $error("result written over an untaken result");

    a_rpm_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TLD) |-> ($past(state_reg) == S_RRUN) && ($past(cnt_reg) == '0))
        else $error("tone division started before rpm division finished");

endmodule

`default_nettype wire
